### src/sdspi_pkg.sv
// Package for the SD card SPI host engine: phase, command and status codes,
// command tables and a payload struct. No dependencies.
package sdspi_pkg;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAKE, PH_CMD, PH_R1, PH_TAIL, PH_TOKEN, PH_RDATA, PH_RCRC,
    PH_WGAP, PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP, PH_WBUSY,
    PH_ACMD_WAIT, PH_END
  } phase_t;

  typedef enum logic [2:0] {
    C_GO_IDLE, C_IF_COND, C_APP, C_OP_COND, C_READ_OCR, C_RD, C_WR
  } cmd_t;

  typedef enum logic [2:0] {
    K_INIT  = 3'd0,
    K_READ  = 3'd1,
    K_WRITE = 3'd2,
    K_XFER  = 3'd3,
    K_TICK  = 3'd4
  } kind_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_TMO = 2'd2;

  localparam logic [1:0] REG_INIT_TMO  = 2'd0;
  localparam logic [1:0] REG_RD_TMO    = 2'd1;
  localparam logic [1:0] REG_WR_TMO    = 2'd2;
  localparam logic [1:0] REG_WAKE_CNT  = 2'd3;

  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;

  typedef struct packed {
    logic [1:0]  status;
    logic        done_res;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        clock_fast;
    logic        chip_select;
    logic [7:0]  mosi_byte;
    logic        send_valid;
  } result_t;

  function automatic logic [5:0] cmd_code(input cmd_t c);
    unique case (c)
      C_GO_IDLE:  cmd_code = 6'd0;
      C_IF_COND:  cmd_code = 6'd8;
      C_APP:      cmd_code = 6'd55;
      C_OP_COND:  cmd_code = 6'd41;
      C_READ_OCR: cmd_code = 6'd58;
      C_RD:       cmd_code = 6'd17;
      C_WR:       cmd_code = 6'd24;
      default:    cmd_code = 6'd0;
    endcase
  endfunction

  function automatic logic [7:0] cmd_crc_byte(input cmd_t c);
    unique case (c)
      C_GO_IDLE: cmd_crc_byte = 8'h95;
      C_IF_COND: cmd_crc_byte = 8'h87;
      default:   cmd_crc_byte = 8'hFF;
    endcase
  endfunction

endpackage

### src/sdspi_cmd_fmt.sv
// Command frame formatter: byte k of the 6-byte SD command frame.
// Depends on sdspi_pkg.
module sdspi_cmd_fmt import sdspi_pkg::*; (
  input  cmd_t        cmd,
  input  logic [2:0]  idx,
  input  logic [31:0] addr,
  output logic [7:0]  frame_byte
);
  logic [31:0] arg;

  always_comb begin
    unique case (cmd)
      C_IF_COND:  arg = 32'h0000_01AA;
      C_OP_COND:  arg = 32'h4000_0000;
      C_RD, C_WR: arg = addr;
      default:    arg = 32'h0;
    endcase
  end

  always_comb begin
    unique case (idx)
      3'd0:    frame_byte = {2'b01, cmd_code(cmd)};
      3'd1:    frame_byte = arg[31:24];
      3'd2:    frame_byte = arg[23:16];
      3'd3:    frame_byte = arg[15:8];
      3'd4:    frame_byte = arg[7:0];
      default: frame_byte = cmd_crc_byte(cmd);
    endcase
  end
endmodule

### src/sd_card_spi_host_engine.sv
// SD card SPI-mode host engine, top level.
// Depends on sdspi_pkg and sdspi_cmd_fmt.
//
// Usage: each input item is a request (kind): start init, start read, start
// write, report of a finished byte exchange (with the received miso byte and
// the next write byte), or a millisecond tick. Each item yields zero or one
// result item: a byte exchange order (send_valid, mosi_byte, chip_select),
// a received data byte (read_valid, read_byte), or completion (done_res,
// status). The caller performs each ordered exchange and reports it back.
// Throughput: one item per cycle unless intake stalls as below. The step
// logic sits between the input register and the result register, so each
// result is registered from the item held in the input register. A result waiting for
// out_tready does not stop intake: the input register keeps taking items
// while the result register is empty or being drained, and stalls only when
// both hold an item and out_tready is low.
// Reset (rst_n low, synchronous) clears both stages, the phase (idle), the
// counters, the card state and loads the register defaults (1000, 200, 500
// ms timeouts, 10 wake bytes). Config writes are taken at any edge with
// cfg_we high and should happen only while idle.
module sd_card_spi_host_engine import sdspi_pkg::*; #(
  parameter int R1_POLL_LIMIT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: kind[2:0], block_number[34:3], miso_byte[42:35], write_byte[50:43]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: send_valid[0], mosi_byte[8:1], chip_select[9], clock_fast[10],
  // read_valid[11], read_byte[19:12], done_res[20], status[22:21]
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  localparam int BLOCK_BYTES = 512;
  localparam int PW = $clog2(R1_POLL_LIMIT + 1);

  // config registers
  logic [15:0] init_tmo_r, rd_tmo_r, wr_tmo_r;
  logic [7:0]  wake_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_tmo_r <= 16'd1000;
      rd_tmo_r   <= 16'd200;
      wr_tmo_r   <= 16'd500;
      wake_cnt_r <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INIT_TMO: init_tmo_r <= cfg_wdata;
        REG_RD_TMO:   rd_tmo_r   <= cfg_wdata;
        REG_WR_TMO:   wr_tmo_r   <= cfg_wdata;
        REG_WAKE_CNT: wake_cnt_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic        iv_r;
  logic [50:0] id_r;
  logic        ov_r;
  result_t     od_r;
  logic        step_go;

  assign step_go   = iv_r && (!ov_r || out_tready);
  assign in_tready = !iv_r || step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) iv_r <= 1'b0;
    else if (in_tready) iv_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) id_r <= in_tdata[50:0];
  end

  logic [2:0]  kind;
  logic [31:0] blk;
  logic [7:0]  b, wb;
  assign kind = id_r[2:0];
  assign blk  = id_r[34:3];
  assign b    = id_r[42:35];
  assign wb   = id_r[50:43];

  // engine state
  phase_t      phase_r, phase_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [9:0]  bcnt_r, bcnt_nxt;
  logic [PW-1:0] poll_r, poll_nxt;
  logic [15:0] ms_r, ms_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [7:0]  resp_r, resp_nxt;
  logic        ready_r, ready_nxt, hc_r, hc_nxt, fast_r, fast_nxt;
  logic [1:0]  pend_r, pend_nxt;

  // command formatter, indexed by the byte about to be sent
  cmd_t        fmt_cmd;
  logic [2:0]  fmt_idx;
  logic [31:0] fmt_addr;
  logic [7:0]  fmt_byte;

  sdspi_cmd_fmt u_fmt (
    .cmd(fmt_cmd), .idx(fmt_idx), .addr(fmt_addr), .frame_byte(fmt_byte)
  );

  logic    emit;
  result_t res;
  logic    r1_done;
  logic [9:0] bc_inc;
  logic [PW-1:0] poll_inc;

  always_comb begin
    phase_nxt = phase_r; cmd_nxt = cmd_r; bcnt_nxt = bcnt_r; poll_nxt = poll_r;
    ms_nxt = ms_r; addr_nxt = addr_r; resp_nxt = resp_r; ready_nxt = ready_r;
    hc_nxt = hc_r; fast_nxt = fast_r; pend_nxt = pend_r;
    emit = 1'b0;
    res = '0;
    fmt_cmd = cmd_r; fmt_idx = 3'd0; fmt_addr = addr_r;
    bc_inc = bcnt_r + 10'd1;
    poll_inc = poll_r + PW'(1);
    r1_done = 1'b0;

    // "send command" shorthand: set command, go CMD, emit frame byte 0
    priority case (kind)
      K_INIT: begin
        fast_nxt = 1'b0; bcnt_nxt = '0; poll_nxt = '0; emit = 1'b1;
        if (wake_cnt_r == 8'd0) begin
          cmd_nxt = C_GO_IDLE; phase_nxt = PH_CMD; fmt_cmd = C_GO_IDLE;
          res.send_valid = 1'b1; res.mosi_byte = fmt_byte; res.chip_select = 1'b1;
        end else begin
          phase_nxt = PH_WAKE;
          res.send_valid = 1'b1; res.mosi_byte = IDLE_BYTE;
        end
      end
      K_READ, K_WRITE: begin
        if (phase_r == PH_IDLE) begin
          emit = 1'b1;
          if (!ready_r) begin
            res.done_res = 1'b1; res.status = ST_ERR;
          end else begin
            addr_nxt = hc_r ? blk : {blk[22:0], 9'd0};
            fmt_addr = addr_nxt;
            cmd_nxt = (kind == K_READ) ? C_RD : C_WR;
            fmt_cmd = cmd_nxt;
            phase_nxt = PH_CMD; bcnt_nxt = '0;
            res.send_valid = 1'b1; res.mosi_byte = fmt_byte; res.chip_select = 1'b1;
          end
        end
      end
      K_TICK: begin
        if (phase_r != PH_IDLE) begin
          if (ms_r != 16'hFFFF) ms_nxt = ms_r + 16'd1;
          if (phase_r == PH_ACMD_WAIT) begin
            emit = 1'b1;
            if (ms_nxt >= init_tmo_r) begin
              phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_TMO;
            end else begin
              cmd_nxt = C_APP; fmt_cmd = C_APP; phase_nxt = PH_CMD; bcnt_nxt = '0;
              res.send_valid = 1'b1; res.mosi_byte = fmt_byte; res.chip_select = 1'b1;
            end
          end
        end
      end
      K_XFER: begin
        if (phase_r != PH_IDLE && phase_r != PH_ACMD_WAIT) begin
          emit = 1'b1;
          res.send_valid = 1'b1; res.mosi_byte = IDLE_BYTE; res.chip_select = 1'b1;
          unique case (phase_r)
            PH_WAKE: begin
              bcnt_nxt = bc_inc;
              if (bc_inc < {2'b00, wake_cnt_r}) begin
                res.chip_select = 1'b0;
              end else begin
                cmd_nxt = C_GO_IDLE; fmt_cmd = C_GO_IDLE; phase_nxt = PH_CMD;
                bcnt_nxt = '0; res.mosi_byte = fmt_byte;
              end
            end
            PH_CMD: begin
              bcnt_nxt = bc_inc;
              if (bc_inc < 10'd6) begin
                fmt_idx = bc_inc[2:0]; res.mosi_byte = fmt_byte;
              end else begin
                phase_nxt = PH_R1; poll_nxt = '0;
              end
            end
            PH_R1: begin
              poll_nxt = poll_inc;
              resp_nxt = b;
              if (!b[7] || poll_inc >= PW'(R1_POLL_LIMIT)) r1_done = 1'b1;
            end
            PH_TAIL: begin
              if (cmd_r == C_IF_COND) begin
                if ((bcnt_r == 10'd2 && b != 8'h01) || (bcnt_r == 10'd3 && b != 8'hAA))
                  pend_nxt = ST_ERR;
              end else if (bcnt_r == 10'd0 && pend_r == ST_OK) begin
                hc_nxt = b[6];
              end
              bcnt_nxt = bc_inc;
              if (bc_inc >= 10'd4) begin
                phase_nxt = PH_END; res.chip_select = 1'b0;
              end
            end
            PH_TOKEN: begin
              if (b == TOKEN_START) begin
                phase_nxt = PH_RDATA; bcnt_nxt = '0;
              end else if (ms_r >= rd_tmo_r) begin
                pend_nxt = ST_TMO; phase_nxt = PH_END; res.chip_select = 1'b0;
              end
            end
            PH_RDATA: begin
              bcnt_nxt = bc_inc;
              if (bc_inc >= 10'(BLOCK_BYTES - 1) && bcnt_r == 10'(BLOCK_BYTES - 1)) begin
                phase_nxt = PH_RCRC; bcnt_nxt = '0;
              end
              res.read_valid = 1'b1; res.read_byte = b;
            end
            PH_RCRC: begin
              bcnt_nxt = bc_inc;
              if (bc_inc >= 10'd2) begin
                pend_nxt = ST_OK; phase_nxt = PH_END; res.chip_select = 1'b0;
              end
            end
            PH_WGAP: begin
              phase_nxt = PH_WTOKEN; res.mosi_byte = TOKEN_START;
            end
            PH_WTOKEN: begin
              phase_nxt = PH_WDATA; bcnt_nxt = '0; res.mosi_byte = wb;
            end
            PH_WDATA: begin
              bcnt_nxt = bc_inc;
              if (bcnt_r != 10'(BLOCK_BYTES - 1)) begin
                res.mosi_byte = wb;
              end else begin
                phase_nxt = PH_WCRC; bcnt_nxt = '0;
              end
            end
            PH_WCRC: begin
              bcnt_nxt = bc_inc;
              if (bc_inc >= 10'd2) phase_nxt = PH_WRESP;
            end
            PH_WRESP: begin
              resp_nxt = b;
              if (b[4:0] != 5'h05) begin
                pend_nxt = ST_ERR; phase_nxt = PH_END; res.chip_select = 1'b0;
              end else begin
                phase_nxt = PH_WBUSY; ms_nxt = '0;
              end
            end
            PH_WBUSY: begin
              if (b == IDLE_BYTE) begin
                pend_nxt = ST_OK; phase_nxt = PH_END; res.chip_select = 1'b0;
              end else if (ms_r >= wr_tmo_r) begin
                pend_nxt = ST_TMO; phase_nxt = PH_END; res.chip_select = 1'b0;
              end
            end
            PH_END: begin
              res = '0;
              priority case (1'b1)
                (cmd_r == C_GO_IDLE || cmd_r == C_IF_COND || cmd_r == C_READ_OCR)
                  && pend_r != ST_OK: begin
                  phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_ERR;
                end
                cmd_r == C_GO_IDLE || cmd_r == C_IF_COND || cmd_r == C_APP
                  || (cmd_r == C_OP_COND && resp_r == 8'h00): begin
                  unique case (cmd_r)
                    C_GO_IDLE: cmd_nxt = C_IF_COND;
                    C_IF_COND: cmd_nxt = C_APP;
                    C_APP:     cmd_nxt = C_OP_COND;
                    default:   cmd_nxt = C_READ_OCR;
                  endcase
                  if (cmd_r == C_IF_COND) ms_nxt = '0;
                  fmt_cmd = cmd_nxt; phase_nxt = PH_CMD; bcnt_nxt = '0;
                  res.send_valid = 1'b1; res.mosi_byte = fmt_byte;
                  res.chip_select = 1'b1;
                end
                cmd_r == C_OP_COND: begin
                  phase_nxt = PH_ACMD_WAIT; emit = 1'b0;
                end
                cmd_r == C_READ_OCR: begin
                  fast_nxt = 1'b1; ready_nxt = 1'b1;
                  phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_OK;
                end
                default: begin
                  phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = pend_r;
                end
              endcase
            end
            default: emit = 1'b0;
          endcase

          if (r1_done) begin
            unique case (cmd_r)
              C_GO_IDLE: begin
                pend_nxt = (b == 8'h01) ? ST_OK : ST_ERR;
                phase_nxt = PH_END; res.chip_select = 1'b0;
              end
              C_IF_COND, C_READ_OCR: begin
                pend_nxt = (b == ((cmd_r == C_IF_COND) ? 8'h01 : 8'h00)) ? ST_OK : ST_ERR;
                phase_nxt = PH_TAIL; bcnt_nxt = '0;
              end
              C_APP, C_OP_COND: begin
                pend_nxt = ST_OK; phase_nxt = PH_END; res.chip_select = 1'b0;
              end
              C_RD: begin
                if (b != 8'h00) begin
                  pend_nxt = ST_ERR; phase_nxt = PH_END; res.chip_select = 1'b0;
                end else begin
                  phase_nxt = PH_TOKEN; ms_nxt = '0;
                end
              end
              default: begin
                if (b != 8'h00) begin
                  pend_nxt = ST_ERR; phase_nxt = PH_END; res.chip_select = 1'b0;
                end else begin
                  phase_nxt = PH_WGAP;
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    res.clock_fast = fast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; cmd_r <= C_GO_IDLE; bcnt_r <= '0; poll_r <= '0;
      ms_r <= '0; addr_r <= '0; resp_r <= 8'hFF; ready_r <= 1'b0; hc_r <= 1'b0;
      fast_r <= 1'b0; pend_r <= ST_OK;
    end else if (step_go) begin
      phase_r <= phase_nxt; cmd_r <= cmd_nxt; bcnt_r <= bcnt_nxt; poll_r <= poll_nxt;
      ms_r <= ms_nxt; addr_r <= addr_nxt; resp_r <= resp_nxt; ready_r <= ready_nxt;
      hc_r <= hc_nxt; fast_r <= fast_nxt; pend_r <= pend_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (step_go) ov_r <= emit;
    else if (out_tready) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (step_go && emit) od_r <= res;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, od_r};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |=> ov_r && $stable(od_r))
    else $error("result changed while stalled");
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !(od_r.send_valid && od_r.done_res))
    else $error("exchange and done in one result");
  a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && emit && res.done_res |-> phase_nxt == PH_IDLE)
    else $error("done without returning idle");
  a_rd_cs: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && od_r.read_valid |-> od_r.chip_select)
    else $error("read data with chip select released");
endmodule

### tb/tb_top.sv
// Self-checking testbench for sd_card_spi_host_engine: plays the SPI caller and
// the card, predicts every result item in place and checks the DUT stream.
// Depends on sdspi_pkg and the engine RTL.
module tb_top import sdspi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_HALF    = 6;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          R1_POLLS    = 8;
  localparam int          BLOCK_LEN   = 512;
  localparam int          DRAIN_WAIT  = 4;    // two-stage pipe plus margin
  localparam logic [2:0]  K_STRAY_LO  = 3'd5; // kinds the block must ignore
  localparam logic [2:0]  K_STRAY_HI  = 3'd7;
  localparam logic [7:0]  R1_IDLE     = 8'h01;
  localparam logic [7:0]  R1_READY    = 8'h00;
  localparam logic [7:0]  R7_ECHO     = 8'hAA;
  localparam logic [7:0]  DATA_ACCEPT = 8'h05;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  sd_card_spi_host_engine dut (.*);

  initial forever #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Engine predictor: own copy of registers and card/protocol state
  // ---------------------------------------------------------------------------
  logic [15:0] reg_init_ms, reg_rd_ms, reg_wr_ms;
  logic [7:0]  reg_wake;
  phase_t      pr_phase;
  cmd_t        pr_cmd;
  logic [9:0]  pr_cnt;
  logic [3:0]  pr_poll;
  logic [15:0] pr_ms;
  logic [31:0] pr_addr;
  logic [7:0]  pr_resp;
  logic [1:0]  pr_pend;
  bit          pr_ready, pr_hc, pr_fast;

  result_t expected_q[$];
  int errors, items_sent, results_seen, data_bytes, n_ok, n_err, n_tmo;
  int in_idle_pct, out_idle_pct, hold_left, cycles;

  function automatic void engine_reset();
    reg_init_ms = 16'd1000; reg_rd_ms = 16'd200; reg_wr_ms = 16'd500; reg_wake = 8'd10;
    pr_phase = PH_IDLE; pr_cmd = C_GO_IDLE; pr_cnt = '0; pr_poll = '0; pr_ms = '0;
    pr_addr = '0; pr_resp = 8'hFF; pr_pend = ST_OK;
    pr_ready = 0; pr_hc = 0; pr_fast = 0;
  endfunction

  function automatic result_t make_res(bit snd, logic [7:0] mosi, bit cs, bit rv,
                                       logic [7:0] rb, bit done, logic [1:0] st);
    result_t r;
    r.send_valid = snd; r.mosi_byte = mosi; r.chip_select = cs; r.clock_fast = pr_fast;
    r.read_valid = rv; r.read_byte = rb; r.done_res = done; r.status = st;
    return r;
  endfunction

  function automatic bit xfer(output result_t r, input logic [7:0] mosi, input bit cs);
    r = make_res(1, mosi, cs, 0, '0, 0, ST_OK);
    return 1;
  endfunction

  function automatic bit finish_op(output result_t r, input logic [1:0] st);
    pr_phase = PH_IDLE;
    r = make_res(0, '0, 0, 0, '0, 1, st);
    return 1;
  endfunction

  // chip select released plus one idle byte closes every command
  function automatic bit end_cmd(output result_t r, input logic [1:0] st);
    pr_pend = st;
    pr_phase = PH_END;
    return xfer(r, IDLE_BYTE, 0);
  endfunction

  // frame byte k of the current command: index, 4 argument bytes, crc
  function automatic logic [7:0] frame_byte(int k);
    logic [5:0]  idx;
    logic [6:0]  crc7;
    logic [31:0] arg;
    case (pr_cmd)
      C_GO_IDLE:  begin idx = 6'd0;  crc7 = 7'h4A; arg = '0; end
      C_IF_COND:  begin idx = 6'd8;  crc7 = 7'h43; arg = 32'h0000_01AA; end
      C_APP:      begin idx = 6'd55; crc7 = 7'h7F; arg = '0; end
      C_OP_COND:  begin idx = 6'd41; crc7 = 7'h7F; arg = 32'h4000_0000; end
      C_READ_OCR: begin idx = 6'd58; crc7 = 7'h7F; arg = '0; end
      C_RD:       begin idx = 6'd17; crc7 = 7'h7F; arg = pr_addr; end
      default:    begin idx = 6'd24; crc7 = 7'h7F; arg = pr_addr; end
    endcase
    if (k == 0) return {2'b01, idx};
    if (k >= 5) return {crc7, 1'b1};
    return arg[8*(4-k) +: 8];
  endfunction

  function automatic bit start_cmd(output result_t r, input cmd_t c);
    pr_cmd = c;
    pr_phase = PH_CMD;
    pr_cnt = '0;
    return xfer(r, frame_byte(0), 1);
  endfunction

  // a finished byte exchange, b received, wb next data byte to send
  function automatic bit on_byte(output result_t r, input logic [7:0] b, input logic [7:0] wb);
    r = '0;
    case (pr_phase)
      PH_WAKE: begin
        pr_cnt++;
        if (pr_cnt < reg_wake) return xfer(r, IDLE_BYTE, 0);
        return start_cmd(r, C_GO_IDLE);
      end
      PH_CMD: begin
        pr_cnt++;
        if (pr_cnt < 6) return xfer(r, frame_byte(pr_cnt), 1);
        pr_phase = PH_R1;
        pr_poll = '0;
        return xfer(r, IDLE_BYTE, 1);
      end
      PH_R1: begin
        pr_poll++;
        pr_resp = b;
        if (b[7] && pr_poll < R1_POLLS) return xfer(r, IDLE_BYTE, 1);
        case (pr_cmd)
          C_GO_IDLE: return end_cmd(r, (b == R1_IDLE) ? ST_OK : ST_ERR);
          C_IF_COND, C_READ_OCR: begin
            pr_pend = (b == ((pr_cmd == C_IF_COND) ? R1_IDLE : R1_READY)) ? ST_OK : ST_ERR;
            pr_phase = PH_TAIL;
            pr_cnt = '0;
            return xfer(r, IDLE_BYTE, 1);
          end
          C_APP, C_OP_COND: return end_cmd(r, ST_OK);
          C_RD: begin
            if (b != R1_READY) return end_cmd(r, ST_ERR);
            pr_phase = PH_TOKEN;
            pr_ms = '0;
            return xfer(r, IDLE_BYTE, 1);
          end
          default: begin
            if (b != R1_READY) return end_cmd(r, ST_ERR);
            pr_phase = PH_WGAP;
            return xfer(r, IDLE_BYTE, 1);
          end
        endcase
      end
      PH_TAIL: begin
        // r7 tail: voltage echo and check pattern; OCR tail: first byte has CCS
        if (pr_cmd == C_IF_COND) begin
          if ((pr_cnt == 2 && b != R1_IDLE) || (pr_cnt == 3 && b != R7_ECHO)) pr_pend = ST_ERR;
        end else if (pr_cnt == 0 && pr_pend == ST_OK) begin
          pr_hc = b[6];
        end
        pr_cnt++;
        if (pr_cnt < 4) return xfer(r, IDLE_BYTE, 1);
        return end_cmd(r, pr_pend);
      end
      PH_TOKEN: begin
        if (b == TOKEN_START) begin
          pr_phase = PH_RDATA;
          pr_cnt = '0;
          return xfer(r, IDLE_BYTE, 1);
        end
        if (pr_ms >= reg_rd_ms) return end_cmd(r, ST_TMO);
        return xfer(r, IDLE_BYTE, 1);
      end
      PH_RDATA: begin
        pr_cnt++;
        if (pr_cnt >= BLOCK_LEN) begin
          pr_phase = PH_RCRC;
          pr_cnt = '0;
        end
        r = make_res(1, IDLE_BYTE, 1, 1, b, 0, ST_OK);
        return 1;
      end
      PH_RCRC: begin
        pr_cnt++;
        if (pr_cnt < 2) return xfer(r, IDLE_BYTE, 1);
        return end_cmd(r, ST_OK);
      end
      PH_WGAP: begin
        pr_phase = PH_WTOKEN;
        return xfer(r, TOKEN_START, 1);
      end
      PH_WTOKEN: begin
        pr_phase = PH_WDATA;
        pr_cnt = '0;
        return xfer(r, wb, 1);
      end
      PH_WDATA: begin
        pr_cnt++;
        if (pr_cnt < BLOCK_LEN) return xfer(r, wb, 1);
        pr_phase = PH_WCRC;
        pr_cnt = '0;
        return xfer(r, IDLE_BYTE, 1);
      end
      PH_WCRC: begin
        pr_cnt++;
        if (pr_cnt >= 2) pr_phase = PH_WRESP;
        return xfer(r, IDLE_BYTE, 1);
      end
      PH_WRESP: begin
        pr_resp = b;
        if (b[4:0] != DATA_ACCEPT[4:0]) return end_cmd(r, ST_ERR);
        pr_phase = PH_WBUSY;
        pr_ms = '0;
        return xfer(r, IDLE_BYTE, 1);
      end
      PH_WBUSY: begin
        if (b == IDLE_BYTE) return end_cmd(r, ST_OK);
        if (pr_ms >= reg_wr_ms) return end_cmd(r, ST_TMO);
        return xfer(r, IDLE_BYTE, 1);
      end
      PH_END: begin
        case (pr_cmd)
          C_GO_IDLE: begin
            if (pr_pend != ST_OK) return finish_op(r, ST_ERR);
            return start_cmd(r, C_IF_COND);
          end
          C_IF_COND: begin
            if (pr_pend != ST_OK) return finish_op(r, ST_ERR);
            pr_ms = '0;
            return start_cmd(r, C_APP);
          end
          C_APP: return start_cmd(r, C_OP_COND);
          C_OP_COND: begin
            if (pr_resp == R1_READY) return start_cmd(r, C_READ_OCR);
            pr_phase = PH_ACMD_WAIT;   // retry on the next tick
            return 0;
          end
          C_READ_OCR: begin
            if (pr_pend != ST_OK) return finish_op(r, ST_ERR);
            pr_fast = 1;
            pr_ready = 1;
            return finish_op(r, ST_OK);
          end
          default: return finish_op(r, pr_pend);
        endcase
      end
      default: return 0;
    endcase
  endfunction

  function automatic bit engine_step(output result_t r, input logic [2:0] k,
                                     input logic [31:0] blk, input logic [7:0] b, wb);
    r = '0;
    case (k)
      K_INIT: begin
        pr_fast = 0;
        pr_cnt = '0;
        pr_poll = '0;
        if (reg_wake == 0) return start_cmd(r, C_GO_IDLE);
        pr_phase = PH_WAKE;
        return xfer(r, IDLE_BYTE, 0);
      end
      K_READ, K_WRITE: begin
        if (pr_phase != PH_IDLE) return 0;
        if (!pr_ready) return finish_op(r, ST_ERR);
        pr_addr = pr_hc ? blk : blk << 9;   // byte address wraps mod 2^32
        return start_cmd(r, (k == K_READ) ? C_RD : C_WR);
      end
      K_XFER: begin
        if (pr_phase == PH_IDLE || pr_phase == PH_ACMD_WAIT) return 0;
        return on_byte(r, b, wb);
      end
      K_TICK: begin
        if (pr_phase == PH_IDLE) return 0;
        if (pr_ms != 16'hFFFF) pr_ms++;
        if (pr_phase != PH_ACMD_WAIT) return 0;
        if (pr_ms >= reg_init_ms) return finish_op(r, ST_TMO);
        return start_cmd(r, C_APP);
      end
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Card emulation: plausible reply for the current phase, sometimes noise
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] card_byte(int bad_pct, int busy_pct);
    logic [7:0] rnd;
    rnd = $urandom;
    if ($urandom_range(99) < bad_pct) return rnd;
    case (pr_phase)
      PH_R1: begin
        if ($urandom_range(99) < busy_pct) return IDLE_BYTE;
        case (pr_cmd)
          C_GO_IDLE, C_IF_COND, C_APP: return R1_IDLE;
          C_OP_COND: return ($urandom_range(99) < 40) ? R1_IDLE : R1_READY;
          default: return R1_READY;
        endcase
      end
      PH_TAIL: begin
        if (pr_cmd == C_IF_COND && pr_cnt == 2) return R1_IDLE;
        if (pr_cmd == C_IF_COND && pr_cnt == 3) return R7_ECHO;
        return rnd;
      end
      PH_TOKEN: return ($urandom_range(99) < 30) ? IDLE_BYTE : TOKEN_START;
      PH_WRESP: return {rnd[7:5], DATA_ACCEPT[4:0]};
      PH_WBUSY: return ($urandom_range(1) == 1) ? IDLE_BYTE : 8'h00;
      default:  return rnd;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [2:0] k, input logic [31:0] blk,
                           input logic [7:0] mb, input logic [7:0] wb);
    result_t r;
    if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, wb, mb, blk, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (engine_step(r, k, blk, mb, wb)) expected_q.push_back(r);
    items_sent++;
  endtask

  // stop offering and let everything in flight come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] init_ms, rd_ms, wr_ms, input logic [7:0] wake);
    cfg_we <= 1'b1; cfg_index <= REG_INIT_TMO; cfg_wdata <= init_ms;
    @(posedge clk);
    cfg_index <= REG_RD_TMO; cfg_wdata <= rd_ms;
    @(posedge clk);
    cfg_index <= REG_WR_TMO; cfg_wdata <= wr_ms;
    @(posedge clk);
    cfg_index <= REG_WAKE_CNT; cfg_wdata <= {8'h00, wake};
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_init_ms = init_ms; reg_rd_ms = rd_ms; reg_wr_ms = wr_ms; reg_wake = wake;
  endtask

  function automatic logic [31:0] pick_block();
    case ($urandom_range(5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed protocol traffic; n items, or with n of zero until the
  // operation under way ends. An operation may carry over into the next call.
  task automatic run_traffic(input int n, input int bad_pct, input int busy_pct);
    int first;
    first = items_sent;
    while (items_sent - first < n || (n == 0 && pr_phase != PH_IDLE)) begin
      if (pr_phase == PH_IDLE) begin
        case ($urandom_range(9))
          0:       send_item(K_INIT, $urandom, $urandom, $urandom);
          1:       send_item($urandom_range(1) ? K_XFER : K_TICK, $urandom, $urandom, $urandom);
          2:       send_item(3'($urandom_range(K_STRAY_LO, K_STRAY_HI)), $urandom, $urandom,
                             $urandom);
          default: send_item(!pr_ready ? K_INIT : ($urandom_range(1) ? K_READ : K_WRITE),
                             pick_block(), $urandom, $urandom);
        endcase
      end else if (pr_phase == PH_ACMD_WAIT) begin
        send_item(K_TICK, $urandom, $urandom, $urandom);
      end else begin
        case ($urandom_range(59))
          0, 1, 2: send_item(K_TICK, $urandom, $urandom, $urandom);
          3:       send_item(3'($urandom_range(K_STRAY_LO, K_STRAY_HI)), $urandom, $urandom,
                             $urandom);
          4:       send_item($urandom_range(1) ? K_READ : K_WRITE, pick_block(), $urandom,
                             $urandom);   // ignored while busy
          5: begin
            if ($urandom_range(19) == 0) send_item(K_INIT, $urandom, $urandom, $urandom);
            else send_item(K_XFER, $urandom, card_byte(bad_pct, busy_pct), $urandom);
          end
          6: begin
            // sender holds back mid-operation until all results are in
            if ($urandom_range(9) == 0) drain();
            send_item(K_XFER, $urandom, card_byte(bad_pct, busy_pct), $urandom);
          end
          default: send_item(K_XFER, $urandom, card_byte(bad_pct, busy_pct), $urandom);
        endcase
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_idle_pct);
      end
      if (out_tvalid && out_tready) begin : check_item
        result_t act, exp;
        act = out_tdata[22:0];
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item %h", $realtime, out_tdata);
        end else begin
          exp = expected_q.pop_front();
          if (act !== exp || out_tdata[23] !== 1'b0) begin
            errors++;
            $display("%0t: mismatch exp snd=%0d mosi=%h cs=%0d fast=%0d rv=%0d rb=%h done=%0d st=%0d",
                     $realtime, exp.send_valid, exp.mosi_byte, exp.chip_select, exp.clock_fast,
                     exp.read_valid, exp.read_byte, exp.done_res, exp.status);
            $display("%0t:      act snd=%0d mosi=%h cs=%0d fast=%0d rv=%0d rb=%h done=%0d st=%0d",
                     $realtime, act.send_valid, act.mosi_byte, act.chip_select, act.clock_fast,
                     act.read_valid, act.read_byte, act.done_res, act.status);
          end
          if (exp.read_valid) data_bytes++;
          if (exp.done_res && exp.status == ST_OK) n_ok++;
          if (exp.done_res && exp.status == ST_ERR) n_err++;
          if (exp.done_res && exp.status == ST_TMO) n_tmo++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $realtime, expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // events that must be ignored when idle, and data requests before init
  task automatic test_idle_requests();
    send_item(K_XFER, 32'h0, 8'hFF, 8'h00);
    send_item(K_TICK, 32'h0, 8'h00, 8'hFF);
    send_item(K_STRAY_LO, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send_item(K_STRAY_HI, 32'h0, 8'h00, 8'h00);
    send_item(K_READ, 32'h0, 8'h00, 8'h00);
    send_item(K_WRITE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    drain();
  endtask

  // init started, aborted by a second init part way, then completed
  task automatic test_init_restart();
    send_item(K_INIT, 32'h0, 8'h00, 8'h00);
    repeat (4) send_item(K_XFER, 32'h0, 8'hFF, 8'h00);
    send_item(K_TICK, 32'h0, 8'h00, 8'h00);
    send_item(K_INIT, 32'h0, 8'h00, 8'h00);
    repeat (3) send_item(K_XFER, 32'h0, 8'hFF, 8'h00);
    run_traffic(0, 0, 10);
  endtask

  // random traffic under one register setting
  task automatic test_traffic(input logic [15:0] init_ms, rd_ms, wr_ms, input logic [7:0] wake,
                              input int n, input int bad_pct, input int busy_pct);
    write_regs(init_ms, rd_ms, wr_ms, wake);
    run_traffic(n, bad_pct, busy_pct);
  endtask

  // result side held off for a long stretch so the pipe fills and stalls intake
  task automatic test_backpressure();
    hold_left = 300;
    run_traffic(150, 2, 20);
  endtask

  initial begin
    engine_reset();
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct = 34; out_idle_pct = 78;
    test_idle_requests();
    test_init_restart();
    test_traffic(16'd1000, 16'd200, 16'd500, 8'd10, 250, 3, 20);

    in_idle_pct = 78; out_idle_pct = 34;
    test_traffic(16'd1, 16'd1, 16'd1, 8'd255, 250, 6, 70);

    in_idle_pct = 0; out_idle_pct = 0;
    test_backpressure();
    test_traffic(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0, 250, 2, 20);
    test_traffic(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                 16'($urandom_range(1, 8)), 8'($urandom_range(10, 20)), 250, 4, 40);

    repeat (8) @(posedge clk);
    $display("Covered %0d items, %0d results, %0d read data bytes;", items_sent,
             results_seen, data_bytes);
    $display("operations ended ok %0d, error %0d, timeout %0d; %0d mismatches.",
             n_ok, n_err, n_tmo, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
